// File: sv/fsnp_pkg.sv
// Shared types, character codes and helpers for the format string number printer.
// Used by fsnp_ctrl, fsnp_dp and format_string_number_printer; depends on nothing.
`default_nettype none

package fsnp_pkg;

  localparam int unsigned ARG_BITS_DEF = 64;
  localparam int unsigned FMT_W        = 8;
  localparam int unsigned ARG_W        = 64;
  localparam int unsigned CNT_W        = 31;
  localparam int unsigned IN_DATA_W    = 72;  // fmt_char + arg_value
  localparam int unsigned OUT_DATA_W   = 40;  // out_char + chars_total, padded to bytes

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  // floor(v / 10) == (v * DEC_RECIP) >> DEC_SHIFT for every 32-bit v
  localparam logic [31:0]      DEC_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned      DEC_SHIFT = 35;

  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'
  localparam logic [7:0] CH_D     = 8'h64;  // 'd'
  localparam logic [7:0] CH_I     = 8'h69;  // 'i'
  localparam logic [7:0] CH_U     = 8'h75;  // 'u'
  localparam logic [7:0] CH_O     = 8'h6F;  // 'o'
  localparam logic [7:0] CH_C     = 8'h63;  // 'c'
  localparam logic [7:0] CH_P     = 8'h70;  // 'p'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'

  // What an input byte asks for
  typedef enum logic [2:0] {
    KD_ARM,   // '%' that opens a conversion, no output
    KD_CHAR,  // one character: echo or %c
    KD_DEC,   // decimal digits
    KD_OCT,   // octal digits
    KD_HEX,   // uppercase hex digits
    KD_PTR    // "0x" and lowercase hex digits
  } kind_t;

  // Source of the next output character
  typedef enum logic [2:0] {
    OS_CHAR,
    OS_DASH,
    OS_ZERO,
    OS_X,
    OS_DIGIT
  } osel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIG,
    S_NEG,
    S_P0,
    S_PX,
    S_OUT,
    S_ONE
  } state_t;

  typedef struct packed {
    logic  accept;  // latch the input beat
    logic  mul;     // register the reciprocal product
    logic  dig;     // store one digit, advance the value
    logic  emit;    // load the output register
    logic  pop;     // drop the top digit
    logic  last;    // last character of this item
    osel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    kind_t in_kind;   // decode of the byte on the input
    kind_t mode;      // latched kind
    logic  neg;       // latched sign
    logic  q_zero;    // value after this digit step is zero
    logic  len_one;   // one digit left
    logic  out_free;  // output register can take a beat
  } dp_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] base;
    begin
      base = lower ? CH_LA : CH_UA;
      digit_char = (d < 4'd10) ? (CH_ZERO + {4'd0, d}) : (base + {4'd0, d} - 8'd10);
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/fsnp_ctrl.sv
// Sequencer of the format string number printer: accept, digit generation, emission.
// Depends on fsnp_pkg; drives fsnp_dp through dp_cmd_t and reads dp_sts_t.
`default_nettype none

module fsnp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire fsnp_pkg::dp_sts_t sts,
  output fsnp_pkg::dp_cmd_t     cmd
);

  fsnp_pkg::state_t state_r, state_nxt;

  // after the digits exist: prefix first, then digits
  function automatic fsnp_pkg::state_t after_digits(input fsnp_pkg::dp_sts_t s);
    begin
      if (s.neg) begin
        after_digits = fsnp_pkg::S_NEG;
      end else if (s.mode == fsnp_pkg::KD_PTR) begin
        after_digits = fsnp_pkg::S_P0;
      end else begin
        after_digits = fsnp_pkg::S_OUT;
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsnp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsnp_pkg::S_IDLE: begin
        if (in_tvalid) begin
          unique case (sts.in_kind)
            fsnp_pkg::KD_ARM:  state_nxt = fsnp_pkg::S_IDLE;
            fsnp_pkg::KD_CHAR: state_nxt = fsnp_pkg::S_ONE;
            fsnp_pkg::KD_DEC:  state_nxt = fsnp_pkg::S_MUL;
            default:           state_nxt = fsnp_pkg::S_DIG;
          endcase
        end
      end
      fsnp_pkg::S_MUL: state_nxt = fsnp_pkg::S_DIG;
      fsnp_pkg::S_DIG: begin
        if (sts.q_zero) begin
          state_nxt = after_digits(sts);
        end else if (sts.mode == fsnp_pkg::KD_DEC) begin
          state_nxt = fsnp_pkg::S_MUL;
        end
      end
      fsnp_pkg::S_NEG: if (sts.out_free) state_nxt = fsnp_pkg::S_OUT;
      fsnp_pkg::S_P0:  if (sts.out_free) state_nxt = fsnp_pkg::S_PX;
      fsnp_pkg::S_PX:  if (sts.out_free) state_nxt = fsnp_pkg::S_OUT;
      fsnp_pkg::S_OUT: if (sts.out_free && sts.len_one) state_nxt = fsnp_pkg::S_IDLE;
      fsnp_pkg::S_ONE: if (sts.out_free) state_nxt = fsnp_pkg::S_IDLE;
      default:         state_nxt = fsnp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    cmd.sel    = fsnp_pkg::OS_CHAR;
    unique case (state_r)
      fsnp_pkg::S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      fsnp_pkg::S_MUL: cmd.mul = 1'b1;
      fsnp_pkg::S_DIG: cmd.dig = 1'b1;
      fsnp_pkg::S_NEG: begin
        cmd.emit = sts.out_free;
        cmd.sel  = fsnp_pkg::OS_DASH;
      end
      fsnp_pkg::S_P0: begin
        cmd.emit = sts.out_free;
        cmd.sel  = fsnp_pkg::OS_ZERO;
      end
      fsnp_pkg::S_PX: begin
        cmd.emit = sts.out_free;
        cmd.sel  = fsnp_pkg::OS_X;
      end
      fsnp_pkg::S_OUT: begin
        cmd.emit = sts.out_free;
        cmd.pop  = sts.out_free;
        cmd.last = sts.len_one;
        cmd.sel  = fsnp_pkg::OS_DIGIT;
      end
      fsnp_pkg::S_ONE: begin
        cmd.emit = sts.out_free;
        cmd.last = 1'b1;
        cmd.sel  = fsnp_pkg::OS_CHAR;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/fsnp_dp.sv
// Datapath of the format string number printer: decode, radix digit unit,
// digit stack, character counter and output register. Depends on fsnp_pkg.
`default_nettype none

module fsnp_dp #(
  parameter int unsigned ARG_BITS = fsnp_pkg::ARG_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [fsnp_pkg::FMT_W-1:0]    fmt_char,
  input  wire logic [fsnp_pkg::ARG_W-1:0]    arg_value,
  input  wire logic                          format_end,
  input  wire fsnp_pkg::dp_cmd_t             cmd,
  output fsnp_pkg::dp_sts_t                  sts,
  input  wire logic                          out_tready,
  output logic                               out_tvalid,
  output logic                               out_tlast,
  output logic [7:0]                         out_char,
  output logic [fsnp_pkg::CNT_W-1:0]         chars_total
);

  localparam int unsigned HEX_DIGITS = (ARG_BITS + 3) / 4;
  localparam int unsigned BUF_DEPTH  = (HEX_DIGITS > 11) ? HEX_DIGITS : 11;
  localparam int unsigned IDX_W      = $clog2(BUF_DEPTH);
  localparam int unsigned LEN_W      = $clog2(BUF_DEPTH + 1);

  logic                         pending_r;
  fsnp_pkg::kind_t              mode_r;
  logic                         neg_r;
  logic [7:0]                   ch_r;
  logic [ARG_BITS-1:0]          val_r;
  logic [63:0]                  prod_r;
  logic [3:0]                   buf_r [BUF_DEPTH];
  logic [LEN_W-1:0]             len_r;
  logic [fsnp_pkg::CNT_W-1:0]   cnt_r;
  logic                         out_valid_r;
  logic                         out_last_r;
  logic [7:0]                   out_char_r;

  // ---- decode of the byte on the input
  fsnp_pkg::kind_t in_kind;
  logic            in_neg;
  logic [7:0]      in_ch;
  logic [31:0]     low;

  assign low = arg_value[31:0];

  always_comb begin
    in_kind = fsnp_pkg::KD_CHAR;
    in_neg  = 1'b0;
    in_ch   = fmt_char;
    if (pending_r) begin
      unique case (fmt_char)
        fsnp_pkg::CH_D, fsnp_pkg::CH_I: begin
          in_kind = fsnp_pkg::KD_DEC;
          in_neg  = low[31];
        end
        fsnp_pkg::CH_U: in_kind = fsnp_pkg::KD_DEC;
        fsnp_pkg::CH_O: in_kind = fsnp_pkg::KD_OCT;
        fsnp_pkg::CH_X: in_kind = fsnp_pkg::KD_HEX;
        fsnp_pkg::CH_P: in_kind = fsnp_pkg::KD_PTR;
        fsnp_pkg::CH_C: in_ch   = arg_value[7:0];
        default:        in_kind = fsnp_pkg::KD_CHAR;
      endcase
    end else if (fmt_char == fsnp_pkg::CH_PCT && !format_end) begin
      in_kind = fsnp_pkg::KD_ARM;
    end
  end

  // ---- one digit step
  logic [28:0]          dec_q;
  logic [31:0]          dec_rem;
  logic [3:0]           dig;
  logic [ARG_BITS-1:0]  val_step;

  assign dec_q   = prod_r[63:fsnp_pkg::DEC_SHIFT];
  assign dec_rem = val_r[31:0] - {dec_q, 3'b000} - {2'b00, dec_q, 1'b0};

  always_comb begin
    unique case (mode_r)
      fsnp_pkg::KD_DEC: begin
        dig      = dec_rem[3:0];
        val_step = ARG_BITS'(dec_q);
      end
      fsnp_pkg::KD_OCT: begin
        dig      = {1'b0, val_r[2:0]};
        val_step = val_r >> 3;
      end
      default: begin
        dig      = val_r[3:0];
        val_step = val_r >> 4;
      end
    endcase
  end

  logic [IDX_W-1:0] wr_idx, rd_idx;
  logic [LEN_W-1:0] len_dec;

  assign len_dec = len_r - LEN_W'(1);
  assign wr_idx  = len_r[IDX_W-1:0];
  assign rd_idx  = len_dec[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_kind;
      neg_r  <= in_neg;
      ch_r   <= in_ch;
      if (in_kind == fsnp_pkg::KD_PTR) begin
        val_r <= arg_value[ARG_BITS-1:0];
      end else if (in_neg) begin
        val_r <= ARG_BITS'(~low + 32'd1);
      end else begin
        val_r <= ARG_BITS'(low);
      end
    end else if (cmd.dig) begin
      val_r <= val_step;
    end
    if (cmd.mul) begin
      prod_r <= val_r[31:0] * fsnp_pkg::DEC_RECIP;
    end
    if (cmd.dig) begin
      buf_r[wr_idx] <= dig;
    end
  end

  // ---- control registers
  logic [7:0] emit_char;

  always_comb begin
    unique case (cmd.sel)
      fsnp_pkg::OS_DASH:  emit_char = fsnp_pkg::CH_DASH;
      fsnp_pkg::OS_ZERO:  emit_char = fsnp_pkg::CH_ZERO;
      fsnp_pkg::OS_X:     emit_char = fsnp_pkg::CH_X;
      fsnp_pkg::OS_DIGIT: emit_char = fsnp_pkg::digit_char(buf_r[rd_idx],
                                                          mode_r == fsnp_pkg::KD_PTR);
      default:            emit_char = ch_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      len_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        pending_r <= (in_kind == fsnp_pkg::KD_ARM);
        len_r     <= '0;
      end else if (cmd.dig) begin
        len_r <= len_r + LEN_W'(1);
      end else if (cmd.pop) begin
        len_r <= len_dec;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (cnt_r != fsnp_pkg::COUNT_MAX) begin
          cnt_r <= cnt_r + fsnp_pkg::CNT_W'(1);
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r <= emit_char;
      out_last_r <= cmd.last;
    end
  end

  assign sts.in_kind  = in_kind;
  assign sts.mode     = mode_r;
  assign sts.neg      = neg_r;
  assign sts.q_zero   = (val_step == '0);
  assign sts.len_one  = (len_r == LEN_W'(1));
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid  = out_valid_r;
  assign out_tlast   = out_last_r;
  assign out_char    = out_char_r;
  assign chars_total = cnt_r;

endmodule

`default_nettype wire

// File: sv/format_string_number_printer.sv
// Top level of the format string number printer: streaming printf engine.
// Depends on fsnp_pkg, fsnp_ctrl and fsnp_dp.
//
// Usage:
//   Input channel (in_*): one beat per format byte. in_tdata carries the byte
//   and the argument, in_tlast marks the last byte of the format string.
//   Output channel (out_*): one beat per printed character. out_tlast is high
//   on the last character caused by one input beat; out_tdata also carries
//   the running character count, which saturates at 2^31-1.
//   A '%' that is not last in the format produces no output beat; the next
//   byte picks the conversion (d i u o x c p), any other byte is echoed.
// Sequencing:
//   One input beat is worked on at a time. A plain byte is latched at accept
//   and then loaded into the output register. Octal and hex take one S_DIG
//   step per digit in the radix unit, decimal an S_MUL step (reciprocal multiply)
//   and then an S_DIG step (remainder), after which every character (sign, "0x"
//   and digits) passes through the output register.
// Reset: synchronous, active low; clears the pending '%', the count and the
//   output valid. Stall: while out_tready is low the held beat stays and the
//   sequencer waits; in_tready is high only between items.
`default_nettype none

module format_string_number_printer #(
  parameter int unsigned ARG_BITS = fsnp_pkg::ARG_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: [7:0] fmt_char, [71:8] arg_value
  input  wire logic [fsnp_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                               in_tlast,    // format_end
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // out_tdata: [7:0] out_char, [38:8] chars_total, [39] zero
  output logic [fsnp_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                    out_tlast,   // run_last
  output logic                                    out_tvalid,
  input  wire logic                               out_tready
);

  fsnp_pkg::dp_cmd_t           cmd;
  fsnp_pkg::dp_sts_t           sts;
  logic [7:0]                  out_char;
  logic [fsnp_pkg::CNT_W-1:0]  chars_total;

  fsnp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fsnp_dp #(
    .ARG_BITS (ARG_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .fmt_char    (in_tdata[7:0]),
    .arg_value   (in_tdata[71:8]),
    .format_end  (in_tlast),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tlast   (out_tlast),
    .out_char    (out_char),
    .chars_total (chars_total)
  );

  // pack the output beat, low field first, pad to whole bytes
  assign out_tdata = {1'b0, chars_total, out_char};

endmodule

`default_nettype wire
